/* rtl/base64_stream_decoder_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the base64 stream decoder.
// Each macro checks on the rising edge of clk_i and is off during reset.
// ----------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_ASSERT_SVH
`define BASE64_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication.
`define B64D_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("base64 decoder check failed");

// Next-cycle implication.
`define B64D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("base64 decoder check failed");

`endif

/* rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character table of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [15:0] MaxBytesReset = 16'hFFFF;

  // Register indexes.
  localparam logic [0:0] RegMaxOutputBytes = 1'b0;

  // Alphabet offsets.
  localparam logic [5:0] LowerBase = 6'd26;
  localparam logic [5:0] DigitBase = 6'd52;
  localparam logic [5:0] PlusCode  = 6'd62;
  localparam logic [5:0] SlashCode = 6'd63;

  // One queue entry: the decoded words caused by one character.
  typedef struct packed {
    logic [1:0]            n;
    logic [2:0][7:0]       bytes;
    logic [CountWidth-1:0] base;
    logic                  done;
  } rec_t;

  // Bit 6 is the valid flag, bits 5..0 the sextet.
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] s;
    s = 7'd0;
    priority if (ch >= 8'h41 && ch <= 8'h5A) begin
      s = {1'b1, 6'(ch - 8'h41)};
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      s = {1'b1, 6'(ch - 8'h61) + LowerBase};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s = {1'b1, 6'(ch - 8'h30) + DigitBase};
    end else if (ch == 8'h2B) begin
      s = {1'b1, PlusCode};
    end else if (ch == 8'h2F) begin
      s = {1'b1, SlashCode};
    end else begin
      s = 7'd0;
    end
    return s;
  endfunction

endpackage

/* rtl/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front
// Maps characters to sextets, groups them in fours, applies the output limit
// and pushes one record per character that causes any word.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [7:0]                    char_i,
  input  logic                          eot_i,
  output logic                          ready_o,
  input  logic [15:0]                   max_i,
  input  logic                          full_i,
  output logic                          push_o,
  output b64d_pkg::rec_t                rec_o
);
  import b64d_pkg::*;

  logic [1:0]            pos_q, pos_d;
  logic [2:0][6:0]       held_q, held_d;
  logic                  stop_q, stop_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;

  logic                  accept;
  logic [6:0]            s;
  logic [5:0]            v2;
  logic [7:0]            b0, b1, b2;
  logic                  decode;
  logic [1:0]            ncand, room, nkeep;
  logic [CountWidth-1:0] diff;

  assign ready_o = !full_i;
  assign accept  = valid_i && !full_i;
  assign s       = sextet_of(char_i);

  always_comb begin
    v2     = held_q[2][6] ? held_q[2][5:0] : 6'h3F;
    b0     = {held_q[0][5:0], held_q[1][5:4]};
    b1     = {held_q[1][3:0], v2[5:2]};
    b2     = {v2[1:0], s[5:0]};
    decode = !stop_q && pos_q == 2'd3 && held_q[0][6] && held_q[1][6];
    ncand  = decode ? 2'd1 + 2'(held_q[2][6]) + 2'(s[6]) : 2'd0;
    diff   = CountWidth'(max_i) - cnt_q;
    if (CountWidth'(max_i) <= cnt_q) begin
      room = 2'd0;
    end else if (diff >= CountWidth'(3)) begin
      room = 2'd3;
    end else begin
      room = diff[1:0];
    end
    nkeep = (ncand < room) ? ncand : room;
  end

  always_comb begin
    rec_o.n        = nkeep;
    rec_o.bytes[0] = b0;
    rec_o.bytes[1] = held_q[2][6] ? b1 : b2;
    rec_o.bytes[2] = b2;
    rec_o.base     = cnt_q;
    rec_o.done     = eot_i;
    push_o         = accept && (nkeep != 2'd0 || eot_i);
  end

  always_comb begin
    pos_d  = pos_q;
    held_d = held_q;
    stop_d = stop_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (!stop_q) begin
        if (pos_q != 2'd3) begin
          held_d[pos_q] = s;
          pos_d         = pos_q + 2'd1;
        end else begin
          pos_d = 2'd0;
          if (!held_q[0][6] || !held_q[1][6]) begin
            stop_d = 1'b1;
          end
        end
      end
      cnt_d = cnt_q + CountWidth'(nkeep);
      if (eot_i) begin
        pos_d  = 2'd0;
        held_d = '0;
        stop_d = 1'b0;
        cnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      held_q <= '0;
      stop_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      held_q <= held_d;
      stop_q <= stop_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* rtl/b64d_queue.sv */
// ----------------------------------------------------------------------------
// b64d_queue
// Short register queue of records between the front and the back part.
// ----------------------------------------------------------------------------
module b64d_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::rec_t rec_i,
  input  logic           pop_i,
  output b64d_pkg::rec_t rec_o,
  output logic           full_o,
  output logic           empty_o
);
  import b64d_pkg::*;

  rec_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QueuePtrW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (QueuePtrW + 1)'(QueueDepth);
  assign empty_o = cnt_q == '0;
  assign rec_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QueuePtrW + 1)'(push_i) - (QueuePtrW + 1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back
// Takes records from the queue and sends their words one per cycle while ready_i is high.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  b64d_pkg::rec_t rec_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           valid_o,
  input  logic           ready_i,
  output logic [7:0]     byte_o,
  output logic           byte_valid_o,
  output logic [15:0]    count_o,
  output logic           last_o,
  output logic           done_o
);
  import b64d_pkg::*;

  rec_t       cur_q, cur_d;
  logic [1:0] idx_q, idx_d;
  logic       busy_q, busy_d;
  logic       fire;
  logic [CountWidth-1:0] cnt;

  assign fire         = busy_q && ready_i;
  assign valid_o      = busy_q;
  assign byte_valid_o = cur_q.n != 2'd0;
  assign last_o       = (cur_q.n == 2'd0) || (idx_q == cur_q.n - 2'd1);
  assign done_o       = cur_q.done && last_o;
  assign cnt          = cur_q.base + CountWidth'(idx_q) + CountWidth'(byte_valid_o);
  assign count_o      = cnt[15:0];

  always_comb begin
    byte_o = 8'd0;
    if (byte_valid_o) begin
      unique case (idx_q)
        2'd0:    byte_o = cur_q.bytes[0];
        2'd1:    byte_o = cur_q.bytes[1];
        default: byte_o = cur_q.bytes[2];
      endcase
    end
  end

  always_comb begin
    cur_d  = cur_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    pop_o  = 1'b0;
    if (fire && !last_o) begin
      idx_d = idx_q + 2'd1;
    end else if (!busy_q || fire) begin
      pop_o  = !empty_i;
      busy_d = !empty_i;
      cur_d  = rec_i;
      idx_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 2'd0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

endmodule

/* rtl/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Decodes base64 text arriving one character per word into bytes.
// ----------------------------------------------------------------------------
// Channel    | Direction | Contents
// s_axis     | in        | tdata: char_in; tlast: end_of_text
// m_axis     | out       | tdata: byte_out, bytes_so_far; tlast: run_last;
//            |           | tuser: byte_valid, message_done
// apb        | in        | max_output_bytes at byte address 0
//
// One character is accepted per cycle while the four-entry queue has room.
// The back part sends one word per cycle while m_axis_tready is high.
// Reset clears the decoder state and sets the byte limit to 65535.
// A stalled output fills the queue, after which s_axis_tready drops.
// ----------------------------------------------------------------------------
`include "base64_stream_decoder_assert.svh"

module base64_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] byte_out, [23:8] bytes_so_far
  output logic        m_axis_tlast,
  output logic [1:0]  m_axis_tuser,   // [0] byte_valid, [1] message_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import b64d_pkg::*;

  logic [15:0] max_q;
  logic        push, pop, full, empty;
  rec_t        rec_in, rec_out;
  logic [7:0]  byte_out;
  logic [15:0] bytes_so_far;

  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == RegMaxOutputBytes) ? {16'd0, max_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxBytesReset;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2:2] == RegMaxOutputBytes) begin
      max_q <= pwdata[15:0];
    end
  end

  b64d_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .char_i  (s_axis_tdata),
    .eot_i   (s_axis_tlast),
    .ready_o (s_axis_tready),
    .max_i   (max_q),
    .full_i  (full),
    .push_o  (push),
    .rec_o   (rec_in)
  );

  b64d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .pop_i   (pop),
    .rec_o   (rec_out),
    .full_o  (full),
    .empty_o (empty)
  );

  b64d_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_i        (rec_out),
    .empty_i      (empty),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid),
    .ready_i      (m_axis_tready),
    .byte_o       (byte_out),
    .byte_valid_o (m_axis_tuser[0]),
    .count_o      (bytes_so_far),
    .last_o       (m_axis_tlast),
    .done_o       (m_axis_tuser[1])
  );

  assign m_axis_tdata = {bytes_so_far, byte_out};

  `B64D_ASSERT_IMPL(a_done_is_last, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
  `B64D_ASSERT_IMPL(a_empty_word_ends_msg, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && m_axis_tuser[1] && byte_out == 8'd0)
  `B64D_ASSERT_IMPL(a_full_blocks_input, full, !s_axis_tready)
  `B64D_ASSERT_NEXT(a_push_fills_queue, push && !pop, !empty)

endmodule
